FILE: sv/kctt_pkg.sv
// Package for the keyed countdown timer table: request and result words, codes.
// No dependencies.
package kctt_pkg;

  localparam int unsigned TableDepthDef = 16;
  localparam int unsigned QueueDepth    = 2;

  typedef enum logic [1:0] {
    REQ_ADD    = 2'd0,
    REQ_REMOVE = 2'd1,
    REQ_TICK   = 2'd2,
    REQ_NONE   = 2'd3
  } req_e;

  typedef enum logic [2:0] {
    EV_MERGED   = 3'd0,
    EV_CREATED  = 3'd1,
    EV_FULL     = 3'd2,
    EV_ZERO     = 3'd3,
    EV_REMOVED  = 3'd4,
    EV_NOTFOUND = 3'd5,
    EV_EXPIRED  = 3'd6,
    EV_TICKDONE = 3'd7
  } event_e;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [7:0]  timer_kind;
    logic        match_position;
    logic [8:0]  pos_x;
    logic [8:0]  pos_y;
    logic [14:0] start_count;
  } in_word_t;

  typedef struct packed {
    logic [2:0]  event_res;
    logic [7:0]  timer_kind_res;
    logic [8:0]  pos_x_res;
    logic [8:0]  pos_y_res;
    logic [14:0] count_now;
    logic        last;
  } out_word_t;

  // classified command handed from front to back
  typedef struct packed {
    req_e        op;
    logic        zero_cnt;
    logic [7:0]  kind;
    logic        bypos;
    logic [8:0]  x;
    logic [8:0]  y;
    logic [14:0] cnt;
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_SCAN  = 2'd1,
    ST_DONE  = 2'd2
  } tick_st_e;

endpackage

FILE: sv/kctt_front.sv
// Front end: accepts request words, masks the key and queues commands.
// Depends on kctt_pkg.
module kctt_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid,
  output logic              in_stall,
  input  kctt_pkg::in_word_t in_data,
  output logic              cmd_valid_o,
  input  logic              cmd_take_i,
  output kctt_pkg::cmd_t    cmd_o
);
  import kctt_pkg::*;

  localparam int unsigned PtrW = $clog2(QueueDepth);

  cmd_t              fifo_q [QueueDepth];
  logic [PtrW-1:0]   wr_q, wr_d, rd_q, rd_d;
  logic [PtrW:0]     cnt_q, cnt_d;
  logic              push, pop;
  cmd_t              cmd_in;

  always_comb begin
    cmd_in.op       = req_e'(in_data.req_type);
    cmd_in.zero_cnt = (in_data.start_count == '0);
    cmd_in.kind     = in_data.timer_kind;
    cmd_in.bypos    = in_data.match_position;
    cmd_in.x        = in_data.match_position ? in_data.pos_x : '0;
    cmd_in.y        = in_data.match_position ? in_data.pos_y : '0;
    cmd_in.cnt      = in_data.start_count;
  end

  assign in_stall    = (cnt_q == (PtrW+1)'(QueueDepth));
  // drop unused request codes here
  assign push        = in_valid && !in_stall && (in_data.req_type != REQ_NONE);
  assign cmd_valid_o = (cnt_q != '0);
  assign pop         = cmd_valid_o && cmd_take_i;
  assign cmd_o       = fifo_q[rd_q];

  always_comb begin
    wr_d  = push ? ((wr_q == PtrW'(QueueDepth-1)) ? '0 : wr_q + 1'b1) : wr_q;
    rd_d  = pop  ? ((rd_q == PtrW'(QueueDepth-1)) ? '0 : rd_q + 1'b1) : rd_q;
    cnt_d = cnt_q + (PtrW+1)'(push) - (PtrW+1)'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) fifo_q[wr_q] <= cmd_in;
  end

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (PtrW+1)'(QueueDepth)) else $error("queue overflow");
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> cnt_q != '0) else $error("pop on empty queue");
  a_cnt_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !pop) |=> cnt_q == $past(cnt_q) + 1'b1) else $error("count slip");
`endif
endmodule

FILE: sv/kctt_back.sv
// Back end: the timer table as a shift array of cells, executes commands.
// Depends on kctt_pkg.
module kctt_back #(
  parameter int unsigned TableDepth = kctt_pkg::TableDepthDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cmd_valid_i,
  output logic               cmd_take_o,
  input  kctt_pkg::cmd_t     cmd_i,
  output logic               out_valid,
  input  logic               out_stall,
  output kctt_pkg::out_word_t out_data
);
  import kctt_pkg::*;

  localparam int unsigned IdxW = $clog2(TableDepth);

  logic        val_q [TableDepth];
  logic [7:0]  kind_q [TableDepth];
  logic [8:0]  x_q [TableDepth];
  logic [8:0]  y_q [TableDepth];
  logic [14:0] cnt_q [TableDepth];

  tick_st_e    st_q, st_d;
  logic        ov_q;
  out_word_t   od_q, od_d;
  logic        ov_d;
  logic        out_free;

  logic [TableDepth-1:0] hit;
  logic [TableDepth-1:0] first_hit;
  logic [TableDepth-1:0] zero_vec;
  logic [TableDepth-1:0] first_zero;
  logic [IdxW-1:0]       hit_idx, zero_idx;
  logic                  any_hit, any_zero, full;

  // table control decided per cycle
  logic do_insert, do_delete, do_merge, do_dec;
  logic [IdxW-1:0] del_idx;

  assign out_free = !ov_q || !out_stall;

  always_comb begin
    for (int i = 0; i < TableDepth; i++) begin
      hit[i] = val_q[i] && (kind_q[i] == cmd_i.kind) &&
               (!cmd_i.bypos || (x_q[i] == cmd_i.x && y_q[i] == cmd_i.y));
      zero_vec[i] = val_q[i] && (cnt_q[i] == '0);
    end
    first_hit  = hit & (~hit + 1'b1);
    first_zero = zero_vec & (~zero_vec + 1'b1);
    hit_idx  = '0;
    zero_idx = '0;
    for (int i = 0; i < TableDepth; i++) begin
      if (first_hit[i])  hit_idx  = IdxW'(i);
      if (first_zero[i]) zero_idx = IdxW'(i);
    end
    any_hit  = |hit;
    any_zero = |zero_vec;
    full     = val_q[TableDepth-1];
  end

  always_comb begin
    st_d = st_q;
    case (st_q)
      ST_IDLE: if (cmd_valid_i && out_free && cmd_i.op == REQ_TICK) st_d = ST_SCAN;
      ST_SCAN: if (out_free && !any_zero) st_d = ST_DONE;
      ST_DONE: if (out_free) st_d = ST_IDLE;
      default: st_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_take_o = 1'b0;
    do_insert  = 1'b0;
    do_delete  = 1'b0;
    do_merge   = 1'b0;
    do_dec     = 1'b0;
    del_idx    = hit_idx;
    ov_d       = ov_q && out_stall;
    od_d       = od_q;
    case (st_q)
      ST_IDLE: begin
        if (cmd_valid_i && out_free && cmd_i.op != REQ_TICK) begin
          cmd_take_o        = 1'b1;
          ov_d              = 1'b1;
          od_d.last         = 1'b1;
          od_d.timer_kind_res = cmd_i.kind;
          od_d.pos_x_res    = cmd_i.x;
          od_d.pos_y_res    = cmd_i.y;
          od_d.count_now    = '0;
          if (cmd_i.op == REQ_ADD) begin
            if (cmd_i.zero_cnt) begin
              od_d.event_res = EV_ZERO;
            end else if (any_hit) begin
              do_merge = 1'b1;
              od_d.event_res      = EV_MERGED;
              od_d.timer_kind_res = kind_q[hit_idx];
              od_d.pos_x_res      = x_q[hit_idx];
              od_d.pos_y_res      = y_q[hit_idx];
              od_d.count_now = (cmd_i.cnt > cnt_q[hit_idx]) ? cmd_i.cnt
                                                            : cnt_q[hit_idx];
            end else if (full) begin
              od_d.event_res = EV_FULL;
            end else begin
              do_insert = 1'b1;
              od_d.event_res = EV_CREATED;
              od_d.count_now = cmd_i.cnt;
            end
          end else begin
            if (any_hit) begin
              do_delete = 1'b1;
              od_d.event_res      = EV_REMOVED;
              od_d.timer_kind_res = kind_q[hit_idx];
              od_d.pos_x_res      = x_q[hit_idx];
              od_d.pos_y_res      = y_q[hit_idx];
            end else begin
              od_d.event_res = EV_NOTFOUND;
            end
          end
        end else if (cmd_valid_i && out_free) begin
          // tick: decrement now, drain expiries in following cycles
          do_dec = 1'b1;
        end
      end
      ST_SCAN: begin
        if (out_free && any_zero) begin
          do_delete = 1'b1;
          del_idx   = zero_idx;
          ov_d      = 1'b1;
          od_d.event_res      = EV_EXPIRED;
          od_d.timer_kind_res = kind_q[zero_idx];
          od_d.pos_x_res      = x_q[zero_idx];
          od_d.pos_y_res      = y_q[zero_idx];
          od_d.count_now      = '0;
          od_d.last           = 1'b0;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          cmd_take_o = 1'b1;
          ov_d       = 1'b1;
          od_d       = '{event_res: EV_TICKDONE, default: '0};
          od_d.last  = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_IDLE;
      ov_q <= 1'b0;
      for (int i = 0; i < TableDepth; i++) val_q[i] <= 1'b0;
    end else begin
      st_q <= st_d;
      ov_q <= ov_d;
      if (do_insert) begin
        val_q[0] <= 1'b1;
        for (int i = 1; i < TableDepth; i++) val_q[i] <= val_q[i-1];
      end else if (do_delete) begin
        for (int i = 0; i < TableDepth - 1; i++)
          if (IdxW'(i) >= del_idx) val_q[i] <= val_q[i+1];
        val_q[TableDepth-1] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    od_q <= od_d;
    if (do_insert) begin
      kind_q[0] <= cmd_i.kind;
      x_q[0]    <= cmd_i.x;
      y_q[0]    <= cmd_i.y;
      cnt_q[0]  <= cmd_i.cnt;
      for (int i = 1; i < TableDepth; i++) begin
        kind_q[i] <= kind_q[i-1];
        x_q[i]    <= x_q[i-1];
        y_q[i]    <= y_q[i-1];
        cnt_q[i]  <= cnt_q[i-1];
      end
    end else if (do_delete) begin
      for (int i = 0; i < TableDepth - 1; i++) begin
        if (IdxW'(i) >= del_idx) begin
          kind_q[i] <= kind_q[i+1];
          x_q[i]    <= x_q[i+1];
          y_q[i]    <= y_q[i+1];
          cnt_q[i]  <= cnt_q[i+1];
        end
      end
    end else if (do_merge) begin
      if (cmd_i.cnt > cnt_q[hit_idx]) cnt_q[hit_idx] <= cmd_i.cnt;
    end else if (do_dec) begin
      for (int i = 0; i < TableDepth; i++)
        if (cnt_q[i] != '0) cnt_q[i] <= cnt_q[i] - 1'b1;
    end
  end

  assign out_valid = ov_q;
  assign out_data  = od_q;

`ifndef NO_ASSERTIONS
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid && out_stall) |=> $stable(out_data) && out_valid)
    else $error("result changed while stalled");
  a_done_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid && out_data.event_res == EV_TICKDONE) |-> out_data.last)
    else $error("tick done without last");
  a_expired_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid && out_data.event_res == EV_EXPIRED) |-> !out_data.last)
    else $error("expiry marked last");
`endif
endmodule

FILE: sv/keyed_countdown_timer_table_core.sv
// Top level of the keyed countdown timer table: front end, command queue, table.
// Depends on kctt_pkg, kctt_front, kctt_back.
//
//  channel | direction | handshake            | word
//  in      | input     | in_valid / in_stall  | kctt_pkg::in_word_t
//  out     | output    | out_valid / out_stall| kctt_pkg::out_word_t
//
// Add and remove are executed in the table once at the queue head and the result register is free.
// A tick runs in steps: one decrement pass, the deletion of each expired cell
// in turn by the shift array, a scan that finds no expired cell left, then
// the done marker.
// Reset empties the table at once (valid bits only).
// A stalled result holds the table; the queue absorbs two requests meanwhile.
module keyed_countdown_timer_table_core #(
  parameter int unsigned TableDepth = kctt_pkg::TableDepthDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid,
  output logic                in_stall,
  input  kctt_pkg::in_word_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output kctt_pkg::out_word_t out_data
);
  import kctt_pkg::*;

  logic cmd_valid, cmd_take;
  cmd_t cmd;

  kctt_front u_front (
    .clk_i, .rst_ni, .in_valid, .in_stall, .in_data,
    .cmd_valid_o(cmd_valid), .cmd_take_i(cmd_take), .cmd_o(cmd)
  );

  kctt_back #(.TableDepth(TableDepth)) u_back (
    .clk_i, .rst_ni, .cmd_valid_i(cmd_valid), .cmd_take_o(cmd_take),
    .cmd_i(cmd), .out_valid, .out_stall, .out_data
  );
endmodule

FILE: verif/tb_keyed_countdown_timer_table_core.sv
// Testbench for keyed_countdown_timer_table_core: random and directed timer requests,
// results checked against an in-bench model of the timer table. Depends on kctt_pkg.
module tb_keyed_countdown_timer_table_core;
  timeunit 1ns;
  timeprecision 1ps;
  import kctt_pkg::*;

  localparam int Depth = TableDepthDef;

  class timer_scoreboard;
    logic        cell_used [Depth];
    logic [7:0]  cell_kind [Depth];
    logic [8:0]  cell_x [Depth];
    logic [8:0]  cell_y [Depth];
    logic [14:0] cell_cnt [Depth];
    out_word_t   pending [$];
    int          errors;

    function new();
      errors = 0;
      foreach (cell_used[i]) cell_used[i] = 1'b0;
    endfunction

    function void push_res(event_e ev, logic [7:0] k, logic [8:0] x, logic [8:0] y,
                           logic [14:0] c, logic lst);
      out_word_t r;
      r.event_res = ev; r.timer_kind_res = k; r.pos_x_res = x; r.pos_y_res = y;
      r.count_now = c; r.last = lst;
      pending.push_back(r);
    endfunction

    function int find_cell(logic [7:0] k, logic bp, logic [8:0] x, logic [8:0] y);
      for (int i = 0; i < Depth; i++)
        if (cell_used[i] && cell_kind[i] == k && (!bp || (cell_x[i] == x && cell_y[i] == y)))
          return i;
      return -1;
    endfunction

    function void drop_cell(int idx);
      for (int i = idx; i < Depth - 1; i++) begin
        cell_used[i] = cell_used[i+1]; cell_kind[i] = cell_kind[i+1];
        cell_x[i] = cell_x[i+1]; cell_y[i] = cell_y[i+1]; cell_cnt[i] = cell_cnt[i+1];
      end
      cell_used[Depth-1] = 1'b0;
    endfunction

    function void note_request(in_word_t w);
      logic [8:0] x, y;
      int idx, n;
      x = w.match_position ? w.pos_x : 9'd0;
      y = w.match_position ? w.pos_y : 9'd0;
      case (req_e'(w.req_type))
        REQ_ADD: begin
          if (w.start_count == 0) begin
            push_res(EV_ZERO, w.timer_kind, x, y, '0, 1'b1);
          end else begin
            idx = find_cell(w.timer_kind, w.match_position, x, y);
            if (idx >= 0) begin
              if (w.start_count > cell_cnt[idx]) cell_cnt[idx] = w.start_count;
              push_res(EV_MERGED, cell_kind[idx], cell_x[idx], cell_y[idx], cell_cnt[idx],
                       1'b1);
            end else begin
              n = 0;
              foreach (cell_used[i]) if (cell_used[i]) n++;
              if (n >= Depth) begin
                push_res(EV_FULL, w.timer_kind, x, y, '0, 1'b1);
              end else begin
                for (int i = Depth - 1; i > 0; i--) begin
                  cell_used[i] = cell_used[i-1]; cell_kind[i] = cell_kind[i-1];
                  cell_x[i] = cell_x[i-1]; cell_y[i] = cell_y[i-1];
                  cell_cnt[i] = cell_cnt[i-1];
                end
                cell_used[0] = 1'b1; cell_kind[0] = w.timer_kind;
                cell_x[0] = x; cell_y[0] = y; cell_cnt[0] = w.start_count;
                push_res(EV_CREATED, w.timer_kind, x, y, w.start_count, 1'b1);
              end
            end
          end
        end
        REQ_REMOVE: begin
          idx = find_cell(w.timer_kind, w.match_position, x, y);
          if (idx < 0) begin
            push_res(EV_NOTFOUND, w.timer_kind, x, y, '0, 1'b1);
          end else begin
            push_res(EV_REMOVED, cell_kind[idx], cell_x[idx], cell_y[idx], '0, 1'b1);
            drop_cell(idx);
          end
        end
        REQ_TICK: begin
          for (int i = 0; i < Depth; i++)
            if (cell_used[i] && cell_cnt[i] > 0) cell_cnt[i] = cell_cnt[i] - 1'b1;
          idx = 0;
          while (idx < Depth) begin
            if (cell_used[idx] && cell_cnt[idx] == 0) begin
              push_res(EV_EXPIRED, cell_kind[idx], cell_x[idx], cell_y[idx], '0, 1'b0);
              drop_cell(idx);
            end else begin
              idx++;
            end
          end
          push_res(EV_TICKDONE, '0, '0, '0, '0, 1'b1);
        end
        default: ;
      endcase
    endfunction

    function void check_result(out_word_t got);
      out_word_t exp_w;
      if (pending.size() == 0) begin
        $error("unexpected result word %h", got);
        errors++;
        return;
      end
      exp_w = pending.pop_front();
      if (got.event_res !== exp_w.event_res) begin
        $error("event_res: expected %0d, got %0d", exp_w.event_res, got.event_res); errors++;
      end
      if (got.timer_kind_res !== exp_w.timer_kind_res) begin
        $error("timer_kind_res: expected %0d, got %0d", exp_w.timer_kind_res,
               got.timer_kind_res); errors++;
      end
      if (got.pos_x_res !== exp_w.pos_x_res) begin
        $error("pos_x_res: expected %0d, got %0d", exp_w.pos_x_res, got.pos_x_res); errors++;
      end
      if (got.pos_y_res !== exp_w.pos_y_res) begin
        $error("pos_y_res: expected %0d, got %0d", exp_w.pos_y_res, got.pos_y_res); errors++;
      end
      if (got.count_now !== exp_w.count_now) begin
        $error("count_now: expected %0d, got %0d", exp_w.count_now, got.count_now); errors++;
      end
      if (got.last !== exp_w.last) begin
        $error("last: expected %0d, got %0d", exp_w.last, got.last); errors++;
      end
    endfunction
  endclass

  logic      clk_i, rst_ni;
  logic      in_valid, in_stall, out_valid, out_stall;
  in_word_t  in_data;
  out_word_t out_data;

  timer_scoreboard sb;
  bit  calm;        // no idling in the final stretch
  bit  hold_off;    // long receiver hold-off
  int  cycles;

  keyed_countdown_timer_table_core #(.TableDepth(Depth)) DUT (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    sb = new();
    rst_ni = 1'b0; in_valid = 1'b0; in_data = '0; out_stall = 1'b0;
    calm = 0; hold_off = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 200000) begin
      $display("tb_keyed_countdown_timer_table_core: done, errors");
      $finish;
    end
  end

  // offer one word, hold it until taken
  task automatic send_word(in_word_t w);
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk_i); while (in_stall);
    sb.note_request(w);
  endtask

  task automatic send_gap();
    int n;
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      n = $urandom_range(1, 16);
      repeat (n) @(posedge clk_i);
    end
  endtask

  function automatic in_word_t mk(req_e op, logic [7:0] k, logic bp, logic [8:0] x,
                                  logic [8:0] y, logic [14:0] c);
    in_word_t w;
    w.req_type = op; w.timer_kind = k; w.match_position = bp;
    w.pos_x = x; w.pos_y = y; w.start_count = c;
    return w;
  endfunction

  // receiver: random stall bursts, one long hold-off on request
  initial begin
    int n;
    @(posedge rst_ni);
    forever begin
      if (hold_off) begin
        out_stall <= 1'b1;
        repeat (150) @(posedge clk_i);
        hold_off = 0;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        n = $urandom_range(1, 16);
        repeat (n) @(posedge clk_i);
      end else begin
        out_stall <= 1'b0;
        n = $urandom_range(1, 12);
        repeat (n) @(posedge clk_i);
      end
    end
  end

  always @(posedge clk_i)
    if (rst_ni && out_valid && !out_stall) sb.check_result(out_data);

  initial begin
    in_word_t w;
    int r;
    @(posedge rst_ni);
    @(posedge clk_i);
    // directed: extremes, each event kind, empty tick, full table
    send_word(mk(REQ_TICK, '0, 1'b0, '0, '0, '0));
    send_word(mk(REQ_ADD, 8'hFF, 1'b1, 9'h1FF, 9'h1FF, '0));
    send_word(mk(REQ_ADD, 8'hFF, 1'b1, 9'h1FF, 9'h1FF, 15'h7FFF));
    send_word(mk(REQ_ADD, 8'hFF, 1'b1, 9'h1FF, 9'h1FF, 15'd5));
    send_word(mk(REQ_ADD, 8'h00, 1'b0, 9'h155, 9'h0AA, 15'd1));
    send_word(mk(REQ_REMOVE, 8'h12, 1'b0, 9'h1FF, 9'h1FF, '0));
    send_word(mk(REQ_REMOVE, 8'hFF, 1'b0, '0, '0, '0));
    send_word(mk(REQ_NONE, 8'h5A, 1'b1, 9'h1FF, 9'h1FF, 15'h7FFF));
    send_word(mk(REQ_TICK, '0, 1'b0, '0, '0, '0));
    for (int i = 0; i < 17; i++)
      send_word(mk(REQ_ADD, 8'(i), 1'b1, 9'(i * 30), 9'(511 - i),
                   15'($urandom_range(1, 3))));
    send_word(mk(REQ_TICK, '0, 1'b0, '0, '0, '0));
    send_word(mk(REQ_TICK, '0, 1'b0, '0, '0, '0));
    send_word(mk(REQ_TICK, '0, 1'b0, '0, '0, '0));
    // random part; hold off the receiver once while words keep coming
    for (int i = 0; i < 81; i++) begin
      if (i == 20) hold_off = 1;
      if (i == 65) calm = 1;
      r = $urandom_range(0, 99);
      w = mk(REQ_ADD, 8'($urandom_range(0, 7)), 1'($urandom_range(0, 1)),
             9'($urandom_range(0, 3)), 9'($urandom_range(0, 3)),
             15'($urandom_range(0, 6)));
      if (r < 5) begin
        w.timer_kind = 8'($urandom); w.pos_x = 9'($urandom); w.pos_y = 9'($urandom);
        w.start_count = 15'($urandom);
      end
      if (r >= 45 && r < 65) w.req_type = REQ_REMOVE;
      else if (r >= 65 && r < 97) w.req_type = REQ_TICK;
      else if (r >= 97) w.req_type = REQ_NONE;
      send_word(w);
      send_gap();
    end
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("tb_keyed_countdown_timer_table_core: done, clean");
    else
      $display("tb_keyed_countdown_timer_table_core: done, errors");
    $finish;
  end
endmodule

FILE: sim.f
sv/kctt_pkg.sv
sv/kctt_front.sv
sv/kctt_back.sv
sv/keyed_countdown_timer_table_core.sv
verif/tb_keyed_countdown_timer_table_core.sv
